// ===== hw/rtl/cqrp_pkg.sv =====
package cqrp_pkg;

	// width of the position and offset arithmetic
	localparam int unsigned POS_W = 32;
	// fixed widths of the ports and of the run-length accumulator
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned FIELD_W = 32;
	localparam int unsigned RUN_W = 32;
	localparam int unsigned RUN_WIDE_W = RUN_W + 4;
	localparam logic [RUN_W-1:0] RUN_MAX = '1;

	localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
	localparam logic [CHAR_W-1:0] CH_0 = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9 = 8'h39;
	localparam logic [CHAR_W-1:0] CH_M = 8'h4D;
	localparam logic [CHAR_W-1:0] CH_X = 8'h58;
	localparam logic [CHAR_W-1:0] CH_EQ = 8'h3D;
	localparam logic [CHAR_W-1:0] CH_N = 8'h4E;
	localparam logic [CHAR_W-1:0] CH_D = 8'h44;
	localparam logic [CHAR_W-1:0] CH_I = 8'h49;
	localparam logic [RUN_WIDE_W-1:0] RADIX = 36'd10;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_LEN   = 3'd1,
		ST_NUM   = 3'd2,
		ST_OPER  = 3'd3,
		ST_LONG  = 3'd4,
		ST_GAP   = 3'd5,
		ST_SHORT = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_BOTH  = 2'd1,
		OP_REF   = 2'd2,
		OP_QUERY = 2'd3
	} op_cls_t;

	function automatic op_cls_t op_class(input logic [CHAR_W-1:0] c);
		op_cls_t k;
		k = OP_NONE;
		if (c == CH_M || c == CH_X || c == CH_EQ) begin
			k = OP_BOTH;
		end else if (c == CH_N || c == CH_D) begin
			k = OP_REF;
		end else if (c == CH_I) begin
			k = OP_QUERY;
		end
		return k;
	endfunction

endpackage

// ===== hw/rtl/cqrp_in_if.sv =====
interface cqrp_in_if import cqrp_pkg::*;;
	logic               valid;
	logic               ready;
	logic [CHAR_W-1:0]  text_char;
	logic [FIELD_W-1:0] query_pos;
	logic [FIELD_W-1:0] seq_len;

	modport source (output valid, text_char, query_pos, seq_len, input ready);
	modport sink (input valid, text_char, query_pos, seq_len, output ready);
endinterface

// ===== hw/rtl/cqrp_out_if.sv =====
interface cqrp_out_if import cqrp_pkg::*;;
	logic               valid;
	logic               ready;
	status_t            status;
	logic [FIELD_W-1:0] ref_pos;

	modport source (output valid, status, ref_pos, input ready);
	modport sink (input valid, status, ref_pos, output ready);
endinterface

// ===== hw/rtl/cigar_query_to_reference_position.sv =====
// CIGAR liftover: CIGAR text enters one byte per transfer on text, each string ending in a NUL
// byte; the first byte of a string also carries the query position and sequence length.
// Every NUL produces exactly one transfer on result with a status and the reference
// position; other bytes produce none. The block takes one byte every cycle unless a NUL is
// stalled: a byte is first held in the input register, and the run-length accumulator, the
// query/reference offsets and the final check are updated as it leaves that register, where a
// NUL also loads its result into the output register. A result waiting there stalls only a NUL
// behind it; ordinary bytes keep flowing, but a stalled NUL also holds back new input.
module cigar_query_to_reference_position import cqrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	cqrp_in_if.sink     text,
	cqrp_out_if.source  result
);

	// input register
	logic               valid_s1;
	logic [CHAR_W-1:0]  char_s1;
	logic [FIELD_W-1:0] qpos_s1;
	logic [FIELD_W-1:0] slen_s1;

	// walk state
	logic               start_q;
	logic               wf_q, wf_d;
	status_t            err_q, err_d;
	logic [RUN_W-1:0]   acc_q, acc_d;
	logic               ds_q, ds_d;
	logic [POS_W-1:0]   qo_q, qo_d;
	logic [POS_W-1:0]   ro_q, ro_d;
	op_cls_t            po_q, po_d;
	logic [POS_W-1:0]   hq_q, hq_d;
	logic [POS_W-1:0]   hs_q, hs_d;

	// result register
	logic               out_valid_q;
	status_t            status_q;
	logic [FIELD_W-1:0] ref_pos_q;

	logic                  nul_s1;
	logic                  digit_s1;
	op_cls_t               cls_s1;
	logic                  adv;
	logic [RUN_WIDE_W-1:0] acc_wide;
	status_t               st_d;
	logic [POS_W-1:0]      rp_d;

	assign nul_s1   = (char_s1 == CH_NUL);
	assign digit_s1 = (char_s1 >= CH_0) && (char_s1 <= CH_9);
	assign cls_s1   = op_class(char_s1);

	// a registered byte moves on unless it is a NUL and the result slot is still full
	assign adv        = valid_s1 && !(nul_s1 && out_valid_q && !result.ready);
	assign text.ready = !valid_s1 || adv;

	// next walk state for the registered byte
	always_comb begin
		wf_d = wf_q;
		err_d = err_q;
		acc_d = acc_q;
		ds_d = ds_q;
		qo_d = qo_q;
		ro_d = ro_q;
		po_d = po_q;
		hq_d = hq_q;
		hs_d = hs_q;
		acc_wide = '0;
		// first byte of a string: fresh walk, sample position and length
		if (start_q) begin
			wf_d = 1'b0;
			acc_d = '0;
			ds_d = 1'b0;
			qo_d = '0;
			ro_d = '0;
			po_d = OP_NONE;
			hq_d = POS_W'(qpos_s1);
			hs_d = POS_W'(slen_s1);
			err_d = (hq_d >= hs_d) ? ST_LEN : ST_OK;
		end
		if (err_d == ST_OK && !wf_d) begin
			if (digit_s1) begin
				// acc * 10 + digit, saturating at the run-length maximum
				acc_wide = RUN_WIDE_W'(acc_d) * RADIX + RUN_WIDE_W'(char_s1 - CH_0);
				acc_d = (acc_wide > RUN_WIDE_W'(RUN_MAX)) ? RUN_MAX : acc_wide[RUN_W-1:0];
				ds_d = 1'b1;
			end else if (nul_s1) begin
				// number left without an operator
				if (ds_d) begin
					err_d = ST_OPER;
				end
			end else if (!ds_d) begin
				err_d = ST_NUM;
			end else if (cls_s1 == OP_NONE) begin
				err_d = ST_OPER;
			end else begin
				if (cls_s1 != OP_QUERY) begin
					ro_d = ro_d + POS_W'(acc_d);
				end
				if (cls_s1 != OP_REF) begin
					qo_d = qo_d + POS_W'(acc_d);
				end
				po_d = cls_s1;
				acc_d = '0;
				ds_d = 1'b0;
				// walked past the query position: ignore the rest of the string
				wf_d = (qo_d > hq_d);
			end
		end
	end

	// final check on the updated state, used only when the byte is a NUL
	always_comb begin
		st_d = ST_OK;
		rp_d = '0;
		if (err_d != ST_OK) begin
			st_d = err_d;
		end else if (qo_d > hs_d) begin
			st_d = ST_LONG;
		end else if (qo_d == hq_d) begin
			rp_d = ro_d;
		end else if (qo_d > hq_d) begin
			// overshoot: back up inside a match, stay put after an insertion, else a gap
			if (po_d == OP_BOTH) begin
				rp_d = ro_d - qo_d + hq_d;
			end else if (po_d == OP_QUERY) begin
				rp_d = ro_d;
			end else begin
				st_d = ST_GAP;
			end
		end else begin
			st_d = ST_SHORT;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			char_s1 <= text.text_char;
			qpos_s1 <= text.query_pos;
			slen_s1 <= text.seq_len;
		end
	end

	// walk state, updated once per byte leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
			wf_q <= 1'b0;
			err_q <= ST_OK;
			acc_q <= '0;
			ds_q <= 1'b0;
			qo_q <= '0;
			ro_q <= '0;
			po_q <= OP_NONE;
			hq_q <= '0;
			hs_q <= '0;
		end else if (adv) begin
			start_q <= nul_s1;
			wf_q <= wf_d;
			err_q <= err_d;
			acc_q <= acc_d;
			ds_q <= ds_d;
			qo_q <= qo_d;
			ro_q <= ro_d;
			po_q <= po_d;
			hq_q <= hq_d;
			hs_q <= hs_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && nul_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && nul_s1) begin
			status_q <= st_d;
			ref_pos_q <= FIELD_W'(rp_d);
		end
	end

	assign result.valid   = out_valid_q;
	assign result.status  = status_q;
	assign result.ref_pos = ref_pos_q;

	// a new result only ever comes from a NUL leaving the input register
	a_result_from_nul: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && nul_s1))
		else $error("result without a terminating byte");

	// failed lookups report a zero position
	a_err_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> (ref_pos_q == '0))
		else $error("nonzero position with error status");

	// a finished walk has gone past the query position
	a_walk_done: assert property (@(posedge clk) disable iff (!arst_n)
		wf_q |-> (qo_q > hq_q))
		else $error("walk finished before passing the query position");

	// a NUL stalled behind a full result slot blocks new input
	a_nul_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && nul_s1 && out_valid_q && !result.ready) |-> !text.ready)
		else $error("input taken while terminating byte is stalled");

endmodule

// ===== tb/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cqrp_pkg::*;

	// receiver hold-off length for the output stall test
	localparam int HOLD_CYCLES = 150;

	// one expected liftover outcome
	typedef struct {
		status_t            status;
		logic [FIELD_W-1:0] ref_pos;
	} lift_t;

	logic clk = 1'b0;
	logic arst_n;

	cqrp_in_if  text_if ();
	cqrp_out_if result_if ();

	cigar_query_to_reference_position u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.result (result_if)
	);

	always #5 clk = ~clk;

	// idle percentages for the text source and the result sink
	int send_idle_pct = 21;
	int recv_idle_pct = 77;
	int bytes_sent = 0;
	int mismatches = 0;

	// outcomes still owed by the block, oldest first
	lift_t pending_lifts[$];

	// long receiver hold-off, counted in its own process
	event long_stall;
	logic receiver_held = 1'b0;

	// walker state, mirrors the block's state after reset
	logic               at_first_byte = 1'b1;
	logic               walk_done = 1'b0;
	status_t            latched_status = ST_OK;
	logic [RUN_W-1:0]   run_len = '0;
	logic               run_has_digits = 1'b0;
	logic [POS_W-1:0]   query_off = '0;
	logic [POS_W-1:0]   ref_off = '0;
	op_cls_t            last_class = OP_NONE;
	logic [POS_W-1:0]   string_qpos = '0;
	logic [POS_W-1:0]   string_len = '0;

	// advance the cigar walk by one accepted byte; a NUL queues its outcome
	task automatic lift_byte(input logic [CHAR_W-1:0] c, input logic [FIELD_W-1:0] qpos,
			input logic [FIELD_W-1:0] slen);
		logic [RUN_WIDE_W-1:0] wide;
		op_cls_t               cls;
		lift_t                 outcome;
		// first byte of a string restarts the walk and samples position and length
		if (at_first_byte) begin
			at_first_byte = 1'b0;
			walk_done = 1'b0;
			latched_status = ST_OK;
			run_len = '0;
			run_has_digits = 1'b0;
			query_off = '0;
			ref_off = '0;
			last_class = OP_NONE;
			string_qpos = POS_W'(qpos);
			string_len = POS_W'(slen);
			if (string_qpos >= string_len) begin
				latched_status = ST_LEN;
			end
		end
		if (latched_status == ST_OK && !walk_done) begin
			if (c >= CH_0 && c <= CH_9) begin
				// decimal run length, saturating at the all-ones value
				wide = RUN_WIDE_W'(run_len) * RADIX + RUN_WIDE_W'(c - CH_0);
				run_len = (wide > RUN_WIDE_W'(RUN_MAX)) ? RUN_MAX : wide[RUN_W-1:0];
				run_has_digits = 1'b1;
			end else if (c == CH_NUL) begin
				if (run_has_digits) begin
					latched_status = ST_OPER;
				end
			end else if (!run_has_digits) begin
				latched_status = ST_NUM;
			end else begin
				case (c)
					CH_M, CH_X, CH_EQ: cls = OP_BOTH;
					CH_N, CH_D:        cls = OP_REF;
					CH_I:              cls = OP_QUERY;
					default:           cls = OP_NONE;
				endcase
				if (cls == OP_NONE) begin
					latched_status = ST_OPER;
				end else begin
					if (cls != OP_QUERY) begin
						ref_off = ref_off + POS_W'(run_len);
					end
					if (cls != OP_REF) begin
						query_off = query_off + POS_W'(run_len);
					end
					last_class = cls;
					run_len = '0;
					run_has_digits = 1'b0;
					// walk stops once the query position has been passed
					if (query_off > string_qpos) begin
						walk_done = 1'b1;
					end
				end
			end
		end
		if (c == CH_NUL) begin
			// final check order: latched error, overrun, hit, overshoot, undershoot
			outcome.status = ST_OK;
			outcome.ref_pos = '0;
			if (latched_status != ST_OK) begin
				outcome.status = latched_status;
			end else if (query_off > string_len) begin
				outcome.status = ST_LONG;
			end else if (query_off == string_qpos) begin
				outcome.ref_pos = FIELD_W'(ref_off);
			end else if (query_off > string_qpos) begin
				if (last_class == OP_BOTH) begin
					outcome.ref_pos = FIELD_W'(ref_off - (query_off - string_qpos));
				end else if (last_class == OP_QUERY) begin
					outcome.ref_pos = FIELD_W'(ref_off);
				end else begin
					outcome.status = ST_GAP;
				end
			end else begin
				outcome.status = ST_SHORT;
			end
			pending_lifts.push_back(outcome);
			at_first_byte = 1'b1;
		end
	endtask

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch at %0t: %s", $realtime, what);
		end
	endtask

	// result sink: check each transfer, then pick ready for the next cycle
	always @(posedge clk) begin
		lift_t want;
		if (result_if.valid && result_if.ready) begin
			if (pending_lifts.size() == 0) begin
				note_mismatch($sformatf("unexpected result status %0d ref_pos %h",
					result_if.status, result_if.ref_pos));
			end else begin
				want = pending_lifts.pop_front();
				if (result_if.status !== want.status) begin
					note_mismatch($sformatf("status expected %0d actual %0d",
						want.status, result_if.status));
				end
				if (result_if.ref_pos !== want.ref_pos) begin
					note_mismatch($sformatf("ref_pos expected %h actual %h",
						want.ref_pos, result_if.ref_pos));
				end
			end
		end
		result_if.ready <= arst_n && !receiver_held && ($urandom_range(99) >= recv_idle_pct);
	end

	// hold the sink off for a fixed stretch whenever asked
	always begin
		@(long_stall);
		receiver_held <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		receiver_held <= 1'b0;
	end

	// offer one byte, with random idle cycles first, and wait for its transfer
	task automatic put_byte(input logic [CHAR_W-1:0] c, input logic [FIELD_W-1:0] qpos,
			input logic [FIELD_W-1:0] slen);
		while ($urandom_range(99) < send_idle_pct) begin
			text_if.valid <= 1'b0;
			@(posedge clk);
		end
		text_if.valid <= 1'b1;
		text_if.text_char <= c;
		text_if.query_pos <= qpos;
		text_if.seq_len <= slen;
		@(posedge clk);
		while (!text_if.ready) @(posedge clk);
		lift_byte(c, qpos, slen);
		bytes_sent++;
	endtask

	// one string plus its NUL; only the first byte carries meaningful position and length
	task automatic send_cigar(input logic [FIELD_W-1:0] qpos, input logic [FIELD_W-1:0] slen,
			input string body);
		for (int i = 0; i < body.len(); i++) begin
			put_byte(body[i], (i == 0) ? qpos : $urandom, (i == 0) ? slen : $urandom);
		end
		put_byte(CH_NUL, (body.len() == 0) ? qpos : $urandom,
			(body.len() == 0) ? slen : $urandom);
	endtask

	// mostly well-formed strings with random runs, some stray bytes and broken tokens
	task automatic random_cigar();
		logic [FIELD_W-1:0] qpos;
		logic [FIELD_W-1:0] slen;
		longint unsigned    run;
		int                 mode;
		int                 pick;
		int                 op_idx;
		string              ops;
		string              body;
		ops = "MX=NDI";
		body = "";
		mode = $urandom_range(99);
		if (mode < 10) begin
			// full-range position and length
			qpos = $urandom;
			slen = $urandom;
		end else if (mode < 16) begin
			// position at or past the length
			slen = $urandom_range(0, 40);
			qpos = slen + $urandom_range(0, 3);
		end else begin
			slen = $urandom_range(1, 80);
			qpos = $urandom_range(0, slen - 1);
		end
		repeat ($urandom_range(0, 5)) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				run = {$urandom, $urandom};
			end else if (mode < 10 && pick < 40) begin
				// land near a large position
				run = 64'(qpos) + $urandom_range(0, 2) - 1;
			end else begin
				run = $urandom_range(0, 12);
			end
			op_idx = $urandom_range(0, 5);
			pick = $urandom_range(99);
			if (pick < 3) begin
				body = {body, $sformatf("%c", 8'($urandom_range(1, 255)))};
			end else if (pick < 6) begin
				body = {body, $sformatf("%c", ops[op_idx])};
			end else begin
				body = {body, $sformatf("%0d%c", run, ops[op_idx])};
			end
		end
		// dangling run length with no operator
		if ($urandom_range(99) < 4) begin
			body = {body, $sformatf("%0d", $urandom_range(0, 99))};
		end
		send_cigar(qpos, slen, body);
	endtask

	// empty string ends the walk at offset zero
	task automatic test_empty_string();
		send_cigar(0, 1, "");
	endtask

	// position at or beyond the length, at both ends of the range
	task automatic test_length_check();
		send_cigar('1, '1, "");
		send_cigar(0, 0, "");
	endtask

	// sign before digits, and operator with no digits
	task automatic test_missing_number();
		send_cigar(2, 9, "+4M");
		send_cigar(2, 9, "M");
	endtask

	// digits closed by the NUL instead of an operator
	task automatic test_bad_operator();
		send_cigar(2, 9, "5");
	endtask

	// run length beyond 32 bits saturates, then overshoot by a match
	task automatic test_run_saturation();
		send_cigar(32'hFFFF_FFFE, '1, "5000000000=");
	endtask

	// insertion passes the position; the stray byte after it is ignored
	task automatic test_walk_stop();
		send_cigar(1, 6, "3D2I#");
	endtask

	task automatic test_random_strings(input int send_pct, input int recv_pct,
			input int n_bytes);
		int target;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		target = bytes_sent + n_bytes;
		while (bytes_sent < target) random_cigar();
	endtask

	// sink held off while short strings keep coming, so the block backs up its input
	task automatic test_output_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		-> long_stall;
		repeat (24) begin
			send_cigar($urandom_range(0, 5), 8, $sformatf("%0dM", $urandom_range(0, 9)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		text_if.valid = 1'b0;
		text_if.text_char = '0;
		text_if.query_pos = '0;
		text_if.seq_len = '0;
		result_if.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_string();
		test_length_check();
		test_missing_number();
		test_bad_operator();
		test_run_saturation();
		test_walk_stop();
		test_random_strings(21, 77, 150);
		test_random_strings(77, 21, 150);
		test_random_strings(0, 0, 150);
		test_output_stall();

		// drain: everything owed, then a few cycles for anything stray
		text_if.valid <= 1'b0;
		while (pending_lifts.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#1_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/cqrp_pkg.sv
hw/rtl/cqrp_in_if.sv
hw/rtl/cqrp_out_if.sv
hw/rtl/cigar_query_to_reference_position.sv
tb/testbench.sv
